// ===== hw/rtl/utc_pkg.sv =====
// Package for the UTF-8 text counter: field widths, byte codes and scanner states.
// It has no dependencies. The interfaces, the top level and the checker use it.
`timescale 1ns / 1ps

package utc_pkg;

  localparam int unsigned BYTE_WIDTH = 8;
  localparam int unsigned OUT_WIDTH  = 48;

  localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

  // Bytes that end a word. A newline also counts a line.
  localparam logic [BYTE_WIDTH-1:0] BYTE_TAB     = 8'h09;
  localparam logic [BYTE_WIDTH-1:0] BYTE_NEWLINE = 8'h0a;
  localparam logic [BYTE_WIDTH-1:0] BYTE_SPACE   = 8'h20;

  // Upper bounds of the byte classes.
  localparam logic [BYTE_WIDTH-1:0] BYTE_ASCII_MAX = 8'h7f;
  localparam logic [BYTE_WIDTH-1:0] BYTE_CONT_MAX  = 8'hbf;
  localparam logic [BYTE_WIDTH-1:0] BYTE_LEAD2_MAX = 8'hdf;
  localparam logic [BYTE_WIDTH-1:0] BYTE_LEAD3_MAX = 8'hef;

  typedef enum logic [3:0] {
    ST_SPACE = 4'b0001,
    ST_WORD  = 4'b0010,
    ST_NEED1 = 4'b0100,
    ST_NEED2 = 4'b1000
  } scan_state_e;

endpackage

// ===== hw/rtl/utc_if.sv =====
// Handshake interfaces of the UTF-8 text counter: the byte channel and the result channel.
// Both depend on utc_pkg for their field widths.
`timescale 1ns / 1ps

interface utc_byte_if;
  logic                             valid;
  logic                             ready;
  logic [utc_pkg::BYTE_WIDTH-1:0]   byte_value;
  logic                             has_byte;
  logic                             end_of_file;

  modport source (output valid, byte_value, has_byte, end_of_file, input ready);
  modport sink   (input valid, byte_value, has_byte, end_of_file, output ready);
endinterface

interface utc_count_if;
  logic                           valid;
  logic                           ready;
  logic [utc_pkg::OUT_WIDTH-1:0]  line_count;
  logic [utc_pkg::OUT_WIDTH-1:0]  word_count;
  logic [utc_pkg::OUT_WIDTH-1:0]  rune_count;
  logic [utc_pkg::OUT_WIDTH-1:0]  bad_rune_count;
  logic [utc_pkg::OUT_WIDTH-1:0]  byte_count;

  modport source (output valid, line_count, word_count, rune_count, bad_rune_count,
                  byte_count, input ready);
  modport sink   (input valid, line_count, word_count, rune_count, bad_rune_count,
                  byte_count, output ready);
endinterface

// ===== hw/rtl/utf8_text_counter.sv =====
// UTF-8 text counter: counts lines, words, runes, bad runes and bytes per file.
// It depends on utc_pkg and on the utc_byte_if and utc_count_if interfaces.
`timescale 1ns / 1ps

// The counter takes one item per clock cycle on in_i and reports one result
// on out_o for every item that has end_of_file set. An accepted item is held
// in an input register; the scanner and the five saturating counters are
// then updated from it in a single pass, and an end-of-file item writes its
// result into the output register. The result waits there, and the block
// goes on taking bytes while it waits; only a second end-of-file item that
// reaches the scanner before the first result is taken holds the input
// side, for as long as out_o stays stalled. Nothing else throttles the rate.
// The counters are COUNT_WIDTH bits wide and saturate at all ones; a count
// that does not fit the 48-bit result fields is reported as 2^48 - 1. After
// each result the counters and the scanner start afresh.
module utf8_text_counter #(
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utc_byte_if.sink    in_i,
  utc_count_if.source out_o
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned OW = utc_pkg::OUT_WIDTH;

  // Saturating add of zero, one or two.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [1:0] amt);
    logic [CW:0] s;
    s = {1'b0, v} + (CW+1)'(amt);
    if (s[CW]) begin
      return '1;
    end else begin
      return s[CW-1:0];
    end
  endfunction

  // Clip a count to the width of the result fields.
  function automatic logic [OW-1:0] clip(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'(utc_pkg::OUT_MAX)) begin
      return utc_pkg::OUT_MAX;
    end else begin
      return w[OW-1:0];
    end
  endfunction

  // Input register.
  logic                           in_vld_q, in_vld_d;
  logic [utc_pkg::BYTE_WIDTH-1:0] in_byte_q;
  logic                           in_has_q;
  logic                           in_eof_q;

  // Scanner and counters.
  utc_pkg::scan_state_e state_q, state_d;
  logic [CW-1:0] lines_q, lines_d;
  logic [CW-1:0] words_q, words_d;
  logic [CW-1:0] runes_q, runes_d;
  logic [CW-1:0] bad_q, bad_d;
  logic [CW-1:0] bytes_q, bytes_d;

  // Output register.
  logic          out_vld_q, out_vld_d;
  logic [OW-1:0] out_lines_q, out_words_q, out_runes_q, out_bad_q, out_bytes_q;

  logic proc;
  logic in_acc;

  // Decoded byte and scanner step.
  logic                 pending;
  logic                 blank;
  logic                 cont;
  logic                 bad;
  logic                 end_bad;
  utc_pkg::scan_state_e scan_next;
  logic [CW-1:0]        lines_n, words_n, runes_n, bad_n, bytes_n;

  // The stored item moves on unless it would produce a second waiting result.
  assign proc     = in_vld_q && (!in_eof_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || proc;
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_vld_d = in_acc || (in_vld_q && !proc);

  always_comb begin
    pending = (state_q == utc_pkg::ST_NEED1) || (state_q == utc_pkg::ST_NEED2);
    blank   = (in_byte_q == utc_pkg::BYTE_TAB) || (in_byte_q == utc_pkg::BYTE_SPACE) ||
              (in_byte_q == utc_pkg::BYTE_NEWLINE);
    cont    = (in_byte_q > utc_pkg::BYTE_ASCII_MAX) && (in_byte_q <= utc_pkg::BYTE_CONT_MAX);

    if (blank) begin
      scan_next = utc_pkg::ST_SPACE;
      bad       = pending;
    end else if (in_byte_q <= utc_pkg::BYTE_ASCII_MAX) begin
      scan_next = utc_pkg::ST_WORD;
      bad       = pending;
    end else if (cont) begin
      if (state_q == utc_pkg::ST_NEED2) begin
        scan_next = utc_pkg::ST_NEED1;
        bad       = 1'b0;
      end else if (state_q == utc_pkg::ST_NEED1) begin
        scan_next = utc_pkg::ST_WORD;
        bad       = 1'b0;
      end else begin
        scan_next = utc_pkg::ST_WORD;
        bad       = 1'b1;
      end
    end else if (in_byte_q <= utc_pkg::BYTE_LEAD2_MAX) begin
      scan_next = utc_pkg::ST_NEED1;
      bad       = pending;
    end else if (in_byte_q <= utc_pkg::BYTE_LEAD3_MAX) begin
      scan_next = utc_pkg::ST_NEED2;
      bad       = pending;
    end else begin
      scan_next = utc_pkg::ST_WORD;
      bad       = 1'b1;
    end

    // An item without a byte leaves the scanner where it is.
    if (!in_has_q) begin
      scan_next = state_q;
      bad       = 1'b0;
    end

    // A rune left partial at the end of the file is one more bad rune.
    end_bad = in_eof_q &&
              ((scan_next == utc_pkg::ST_NEED1) || (scan_next == utc_pkg::ST_NEED2));

    bytes_n = sat_add(bytes_q, {1'b0, in_has_q});
    runes_n = sat_add(runes_q, {1'b0, in_has_q && !(pending && cont)});
    words_n = sat_add(words_q, {1'b0, in_has_q && (state_q == utc_pkg::ST_SPACE) && !blank});
    lines_n = sat_add(lines_q, {1'b0, in_has_q && (in_byte_q == utc_pkg::BYTE_NEWLINE)});
    bad_n   = sat_add(bad_q, 2'(bad) + 2'(end_bad));
  end

  always_comb begin
    state_d = state_q;
    lines_d = lines_q;
    words_d = words_q;
    runes_d = runes_q;
    bad_d   = bad_q;
    bytes_d = bytes_q;
    if (proc) begin
      if (in_eof_q) begin
        state_d = utc_pkg::ST_SPACE;
        lines_d = '0;
        words_d = '0;
        runes_d = '0;
        bad_d   = '0;
        bytes_d = '0;
      end else begin
        state_d = scan_next;
        lines_d = lines_n;
        words_d = words_n;
        runes_d = runes_n;
        bad_d   = bad_n;
        bytes_d = bytes_n;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    if (proc && in_eof_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= utc_pkg::ST_SPACE;
      lines_q   <= '0;
      words_q   <= '0;
      runes_q   <= '0;
      bad_q     <= '0;
      bytes_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      state_q   <= state_d;
      lines_q   <= lines_d;
      words_q   <= words_d;
      runes_q   <= runes_d;
      bad_q     <= bad_d;
      bytes_q   <= bytes_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.byte_value;
      in_has_q  <= in_i.has_byte;
      in_eof_q  <= in_i.end_of_file;
    end
    if (proc && in_eof_q) begin
      out_lines_q <= clip(lines_n);
      out_words_q <= clip(words_n);
      out_runes_q <= clip(runes_n);
      out_bad_q   <= clip(bad_n);
      out_bytes_q <= clip(bytes_n);
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.line_count     = out_lines_q;
  assign out_o.word_count     = out_words_q;
  assign out_o.rune_count     = out_runes_q;
  assign out_o.bad_rune_count = out_bad_q;
  assign out_o.byte_count     = out_bytes_q;

endmodule

// ===== hw/rtl/utc_checker.sv =====
// Port checker for the UTF-8 text counter, bound to its top level.
// It depends on utc_pkg and sees only the ports of utf8_text_counter.
`timescale 1ns / 1ps

module utc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [utc_pkg::OUT_WIDTH-1:0] line_count_i,
  input logic [utc_pkg::OUT_WIDTH-1:0] word_count_i,
  input logic [utc_pkg::OUT_WIDTH-1:0] rune_count_i,
  input logic [utc_pkg::OUT_WIDTH-1:0] byte_count_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its byte and rune counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(byte_count_i) && $stable(rune_count_i))
    else $error("result changed while stalled");

  // The input side only waits behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input held without a waiting result");

  // Each byte adds at most one rune, one word start and one line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (rune_count_i <= byte_count_i) && (word_count_i <= byte_count_i) &&
                    (line_count_i <= byte_count_i))
    else $error("count exceeds byte count");

endmodule

bind utf8_text_counter utc_checker u_utc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_count_i (out_o.line_count),
  .word_count_i (out_o.word_count),
  .rune_count_i (out_o.rune_count),
  .byte_count_i (out_o.byte_count)
);
